/* sv/ugd_pkg.sv */
`timescale 1ns / 1ps
// Package for the UTF-8 glyph decoder: event type, queue depth and the glyph table.
// No dependencies; used by every module of the decoder.
package ugd_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int CP_W = 21;
    localparam int GLYPH_W = 8;
    localparam int TABLE_N = 12;

    localparam logic [7:0] ASCII_OFFSET = 8'd32;

    localparam logic [CP_W-1:0] GLYPH_KEYS [TABLE_N] = '{
        21'h0000C9, 21'h0000D3, 21'h0000DF, 21'h0000E1, 21'h0000E4, 21'h0000E9,
        21'h0000ED, 21'h0000F1, 21'h0000F3, 21'h0000F6, 21'h0000FA, 21'h0000FC
    };

    localparam logic [GLYPH_W-1:0] GLYPH_VALS [TABLE_N] = '{
        8'd37, 8'd47, 8'd107, 8'd92, 8'd94, 8'd95,
        8'd73, 8'd108, 8'd99, 8'd102, 8'd103, 8'd106
    };

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            decode_error;
        logic            end_of_string;
    } t_evt;

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [CP_W-1:0] cp);
        logic [GLYPH_W-1:0] g;
        g = '0;
        if (cp < CP_W'(128)) begin
            g = cp[GLYPH_W-1:0] - ASCII_OFFSET;
        end else begin
            for (int k = 0; k < TABLE_N; k++) begin
                if (GLYPH_KEYS[k] == cp) begin
                    g = GLYPH_VALS[k];
                end
            end
        end
        return g;
    endfunction

endpackage

/* sv/utf8_glyph_decoder.sv */
`timescale 1ns / 1ps
// UTF-8 glyph decoder: turns a UTF-8 byte stream into code points and font glyph indexes.
// Depends on ugd_pkg, ugd_front, ugd_queue and ugd_back.
//
// The input channel carries one raw byte per request on i_valid / o_stall. The
// output channel carries one result per request on o_valid / i_stall: code point,
// signed glyph index, decode error flag and end-of-string flag. A byte that starts
// or continues a multi-byte sequence gives no result; the byte that completes a
// character, a malformed byte and a NUL byte while idle each give one result.
// One byte is taken every cycle while o_stall is low. A result passes through the
// event queue entry and then the output register before it appears on the output.
// The front decode runs in the cycle the byte is taken. The glyph table compare
// runs in parallel in front of the output register. When the receiver stalls, the
// output holds and the queue fills; o_stall rises only while the queue is full.
// Reset returns the decoder to idle with no sequence pending and empties the queue
// and output register.
module utf8_glyph_decoder #(
    parameter int P_QUEUE_DEPTH = ugd_pkg::QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [7:0]                         i_text_byte,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [ugd_pkg::CP_W-1:0]           o_code_point,
    output logic signed [ugd_pkg::GLYPH_W-1:0] o_glyph,
    output logic                               o_decode_error,
    output logic                               o_end_of_string
);
    import ugd_pkg::*;

    logic full;
    logic empty;
    logic push;
    logic pop;
    t_evt front_evt;
    t_evt queue_evt;

    assign o_stall = full;

    ugd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_full      (full),
        .i_text_byte (i_text_byte),
        .o_push      (push),
        .o_evt       (front_evt)
    );

    ugd_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (front_evt),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_evt   (queue_evt)
    );

    ugd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_evt           (queue_evt),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_code_point    (o_code_point),
        .o_glyph         (o_glyph),
        .o_decode_error  (o_decode_error),
        .o_end_of_string (o_end_of_string)
    );

endmodule

/* sv/ugd_front.sv */
`timescale 1ns / 1ps
// Front part of the UTF-8 glyph decoder: takes bytes, tracks pending continuation
// bytes, assembles code points and pushes finished events. Depends on ugd_pkg.
module ugd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_full,
    input  logic [7:0]         i_text_byte,
    output logic               o_push,
    output ugd_pkg::t_evt      o_evt
);
    import ugd_pkg::*;

    logic [1:0]      r_pending;
    logic [CP_W-1:0] r_partial;
    logic [1:0]      n_pending;
    logic [CP_W-1:0] n_partial;
    logic [1:0]      dec_pending;
    logic [CP_W-1:0] cont_bits;
    logic            emit;
    t_evt            evt;
    logic            take;

    assign take = i_valid && !i_full;
    assign dec_pending = r_pending - 2'd1;

    always_comb begin
        case (dec_pending)
            2'd2:    cont_bits = CP_W'({i_text_byte[5:0], 12'd0});
            2'd1:    cont_bits = CP_W'({i_text_byte[5:0], 6'd0});
            default: cont_bits = CP_W'(i_text_byte[5:0]);
        endcase
    end

    always_comb begin
        n_pending = r_pending;
        n_partial = r_partial;
        emit = 1'b0;
        evt = '0;
        if (r_pending == 2'd0) begin
            if (i_text_byte == 8'h00) begin
                emit = 1'b1;
                evt.end_of_string = 1'b1;
            end else if (!i_text_byte[7]) begin
                emit = 1'b1;
                evt.code_point = CP_W'(i_text_byte);
            end else if (i_text_byte[7:5] == 3'b110) begin
                n_partial = CP_W'({i_text_byte[4:0], 6'd0});
                n_pending = 2'd1;
            end else if (i_text_byte[7:4] == 4'b1110) begin
                n_partial = CP_W'({i_text_byte[3:0], 12'd0});
                n_pending = 2'd2;
            end else if (i_text_byte[7:3] == 5'b11110) begin
                n_partial = CP_W'({i_text_byte[2:0], 18'd0});
                n_pending = 2'd3;
            end else begin
                emit = 1'b1;
                evt.decode_error = 1'b1;
            end
        end else if (i_text_byte[7:6] != 2'b10) begin
            emit = 1'b1;
            evt.decode_error = 1'b1;
            n_pending = 2'd0;
            n_partial = '0;
        end else begin
            n_pending = dec_pending;
            if (dec_pending == 2'd0) begin
                emit = 1'b1;
                evt.code_point = r_partial | cont_bits;
                n_partial = '0;
            end else begin
                n_partial = r_partial | cont_bits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= '0;
        end else if (take) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
        end
    end

    assign o_push = take && emit;
    assign o_evt  = evt;

    a_pending_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_evt.decode_error) |=> (r_pending == 2'd0))
        else $error("Pending count not cleared after a decode error.");

    a_idle_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == 2'd0) |-> (r_partial == '0) || $past(take))
        else $error("Partial code point left over while idle.");

endmodule

/* sv/ugd_queue.sv */
`timescale 1ns / 1ps
// Short event queue between the front and back parts of the UTF-8 glyph decoder.
// Depends on ugd_pkg for the event type.
module ugd_queue #(
    parameter int P_DEPTH = ugd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ugd_pkg::t_evt i_evt,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output ugd_pkg::t_evt o_evt
);
    import ugd_pkg::*;

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(P_DEPTH);

    t_evt             r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_pop  = i_pop && !o_empty;
    assign o_evt   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("Event pushed into a full queue.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("Queue count beyond depth.");

endmodule

/* sv/ugd_back.sv */
`timescale 1ns / 1ps
// Back part of the UTF-8 glyph decoder: looks up the font glyph of each event and
// holds the result in the output register. Depends on ugd_pkg.
module ugd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  ugd_pkg::t_evt              i_evt,
    output logic                       o_pop,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic [ugd_pkg::CP_W-1:0]   o_code_point,
    output logic signed [ugd_pkg::GLYPH_W-1:0] o_glyph,
    output logic                       o_decode_error,
    output logic                       o_end_of_string
);
    import ugd_pkg::*;

    logic               r_valid;
    logic [CP_W-1:0]    r_code_point;
    logic [GLYPH_W-1:0] r_glyph;
    logic               r_err;
    logic               r_eos;
    logic               load;
    logic [GLYPH_W-1:0] n_glyph;

    assign load  = !r_valid || !i_stall;
    assign o_pop = load && !i_empty;

    always_comb begin
        if (i_evt.decode_error || i_evt.end_of_string) begin
            n_glyph = '0;
        end else begin
            n_glyph = glyph_of(i_evt.code_point);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_code_point <= i_evt.code_point;
            r_glyph      <= n_glyph;
            r_err        <= i_evt.decode_error;
            r_eos        <= i_evt.end_of_string;
        end
    end

    assign o_valid         = r_valid;
    assign o_code_point    = r_code_point;
    assign o_glyph         = r_glyph;
    assign o_decode_error  = r_err;
    assign o_end_of_string = r_eos;

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_err && r_eos))
        else $error("Error and end-of-string flagged together.");

    a_flag_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_err || r_eos)) |-> (r_code_point == '0) && (r_glyph == '0))
        else $error("Error or end-of-string request carries a nonzero payload.");

endmodule

/* sim/utf8_glyph_decoder_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for utf8_glyph_decoder: directed and random UTF-8 byte streams.
// Depends on ugd_pkg and utf8_glyph_decoder; predicts code points and glyph indexes itself.
module utf8_glyph_decoder_tb;

    typedef struct packed {
        logic                                code_point_w_pad;
        logic [ugd_pkg::CP_W-1:0]            code_point;
        logic signed [ugd_pkg::GLYPH_W-1:0]  glyph;
        logic                                decode_error;
        logic                                end_of_string;
    } glyph_result_t;

    typedef struct packed {
        logic       pause;
        logic [7:0] value;
    } text_item_t;

    // Low bytes of the twelve code points that have their own glyph.
    localparam logic [12*8-1:0] TABLE_CODES = {
        8'hC9, 8'hD3, 8'hDF, 8'hE1, 8'hE4, 8'hE9,
        8'hED, 8'hF1, 8'hF3, 8'hF6, 8'hFA, 8'hFC
    };
    localparam int TAIL_BYTES = 150;
    localparam int HOLDOFF_AT = 500;
    localparam int HOLDOFF_CYCLES = 150;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic [7:0]                         i_text_byte = 8'h00;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    logic [ugd_pkg::CP_W-1:0]           o_code_point;
    logic signed [ugd_pkg::GLYPH_W-1:0] o_glyph;
    logic                               o_decode_error;
    logic                               o_end_of_string;

    text_item_t                 pending_bytes[$];
    glyph_result_t              expected_results[$];
    logic [1:0]                 seq_left = 2'd0;
    logic [ugd_pkg::CP_W-1:0]   partial_cp = '0;
    int                         stim_bytes = 0;
    int                         bytes_sent = 0;
    int                         results_seen = 0;
    int                         mismatches = 0;
    int                         send_gap = 0;
    bit                         wait_drain = 1'b0;
    bit                         quiet_tail = 1'b0;
    int                         stall_gap = 0;
    int                         holdoff_left = 0;
    bit                         holdoff_done = 1'b0;

    utf8_glyph_decoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_text_byte     (i_text_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_code_point    (o_code_point),
        .o_glyph         (o_glyph),
        .o_decode_error  (o_decode_error),
        .o_end_of_string (o_end_of_string)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [7:0] glyph_index(input logic [ugd_pkg::CP_W-1:0] cp);
        if (cp < 21'd128) begin
            return cp[7:0] - 8'd32;
        end
        case (cp)
            21'h0000C9: return 8'sd37;
            21'h0000D3: return 8'sd47;
            21'h0000DF: return 8'sd107;
            21'h0000E1: return 8'sd92;
            21'h0000E4: return 8'sd94;
            21'h0000E9: return 8'sd95;
            21'h0000ED: return 8'sd73;
            21'h0000F1: return 8'sd108;
            21'h0000F3: return 8'sd99;
            21'h0000F6: return 8'sd102;
            21'h0000FA: return 8'sd103;
            21'h0000FC: return 8'sd106;
            default: return 8'sd0;
        endcase
    endfunction

    // Advances the decode state by one byte and queues the result it produces, if any.
    task automatic decode_byte(input logic [7:0] b);
        glyph_result_t r;
        bit            emit;
        r = '0;
        emit = 1'b0;
        if (seq_left == 2'd0) begin
            if (b == 8'h00) begin
                emit = 1'b1;
                r.end_of_string = 1'b1;
            end else if (b[7] == 1'b0) begin
                emit = 1'b1;
                r.code_point = {14'd0, b[6:0]};
            end else if (b[7:5] == 3'b110) begin
                partial_cp = {10'd0, b[4:0], 6'd0};
                seq_left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                partial_cp = {5'd0, b[3:0], 12'd0};
                seq_left = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                partial_cp = {b[2:0], 18'd0};
                seq_left = 2'd3;
            end else begin
                emit = 1'b1;
                r.decode_error = 1'b1;
            end
        end else if (b[7:6] != 2'b10) begin
            seq_left = 2'd0;
            partial_cp = '0;
            emit = 1'b1;
            r.decode_error = 1'b1;
        end else begin
            seq_left = seq_left - 2'd1;
            partial_cp = partial_cp | (21'(b[5:0]) << (6 * seq_left));
            if (seq_left == 2'd0) begin
                emit = 1'b1;
                r.code_point = partial_cp;
                partial_cp = '0;
            end
        end
        if (emit) begin
            r.glyph = (r.decode_error || r.end_of_string) ? 8'sd0 : glyph_index(r.code_point);
            expected_results.push_back(r);
        end
    endtask

    function automatic bit idle_roll(input int count);
        int unsigned pct;
        case ((count / 200) % 4)
            0: pct = 0;
            1: pct = 6;
            2: pct = 20;
            default: pct = 45;
        endcase
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic add_byte(input logic [7:0] b);
        text_item_t it;
        it.pause = 1'b0;
        it.value = b;
        pending_bytes.push_back(it);
        stim_bytes++;
    endtask

    task automatic add_pause();
        text_item_t it;
        it.pause = 1'b1;
        it.value = 8'h00;
        pending_bytes.push_back(it);
    endtask

    task automatic add_lead(input int len, input logic [31:0] r);
        case (len)
            1: add_byte({3'b110, r[4:0]});
            2: add_byte({4'b1110, r[3:0]});
            default: add_byte({5'b11110, r[2:0]});
        endcase
    endtask

    task automatic add_random_sequences();
        logic [31:0] r;
        int          pick;
        int          len;
        int          k;
        while (stim_bytes < 1750) begin
            if (stim_bytes >= 900 && stim_bytes < 904) begin
                add_pause();
            end
            r = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                add_byte(8'($urandom_range(1, 127)));
            end else if (pick < 48) begin
                k = $urandom_range(0, 11);
                add_byte({6'b110000, TABLE_CODES[k*8+6 +: 2]});
                add_byte({2'b10, TABLE_CODES[k*8 +: 6]});
            end else if (pick < 85) begin
                len = (pick < 63) ? 1 : (pick < 76) ? 2 : 3;
                add_lead(len, r);
                for (k = 0; k < len; k++) begin
                    add_byte({2'b10, 6'($urandom)});
                end
            end else if (pick < 90) begin
                add_byte(8'h00);
            end else if (pick < 95) begin
                k = $urandom_range(0, 71);
                add_byte((k < 64) ? 8'(8'h80 + k) : 8'(8'hF8 + k - 64));
            end else begin
                // A sequence cut short by a byte that is not a continuation.
                len = $urandom_range(1, 3);
                add_lead(len, r);
                for (k = $urandom_range(0, len - 1); k > 0; k--) begin
                    add_byte({2'b10, 6'($urandom)});
                end
                k = $urandom_range(0, 191);
                add_byte((k < 128) ? 8'(k) : 8'(k + 64));
            end
        end
    endtask

    always @(posedge i_clk) begin
        logic       nv;
        logic [7:0] nb;
        text_item_t it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_text_byte <= 8'h00;
        end else begin
            if (i_valid && !o_stall) begin
                decode_byte(i_text_byte);
                bytes_sent++;
                quiet_tail = (bytes_sent + TAIL_BYTES >= stim_bytes);
            end
            if (!(i_valid && o_stall)) begin
                nv = 1'b0;
                nb = i_text_byte;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (wait_drain) begin
                    if (expected_results.size() == 0) begin
                        wait_drain = 1'b0;
                    end
                end else if (pending_bytes.size() > 0) begin
                    if (!quiet_tail && idle_roll(bytes_sent)) begin
                        send_gap = $urandom_range(1, 16) - 1;
                    end else begin
                        it = pending_bytes.pop_front();
                        if (it.pause) begin
                            wait_drain = 1'b1;
                        end else begin
                            nv = 1'b1;
                            nb = it.value;
                        end
                    end
                end
                i_valid <= nv;
                i_text_byte <= nb;
            end
        end
    end

    always @(posedge i_clk) begin
        glyph_result_t want;
        logic          ns;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result: cp=%h glyph=%0d err=%b eos=%b",
                                 o_code_point, o_glyph, o_decode_error, o_end_of_string);
                    end
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_code_point !== want.code_point || o_glyph !== want.glyph ||
                        o_decode_error !== want.decode_error ||
                        o_end_of_string !== want.end_of_string) begin
                        if (mismatches < 10) begin
                            $display("mismatch: expected cp=%h glyph=%0d err=%b eos=%b, got cp=%h glyph=%0d err=%b eos=%b",
                                     want.code_point, want.glyph, want.decode_error,
                                     want.end_of_string, o_code_point, o_glyph,
                                     o_decode_error, o_end_of_string);
                        end
                        mismatches++;
                    end
                end
            end
            ns = 1'b0;
            if (holdoff_left > 0) begin
                holdoff_left--;
                ns = 1'b1;
            end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
                // Long hold-off so the output queue fills and the decoder stalls its input.
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES - 1;
                ns = 1'b1;
            end else if (stall_gap > 0) begin
                stall_gap--;
                ns = 1'b1;
            end else if (!quiet_tail && idle_roll(results_seen)) begin
                stall_gap = $urandom_range(1, 16) - 1;
                ns = 1'b1;
            end
            i_stall <= ns;
        end
    end

    initial begin
        // Plain ASCII, end of string, control code points and table hits and misses.
        add_byte(8'h41);
        add_byte(8'h00);
        add_byte(8'h7F);
        add_byte(8'h01);
        add_byte(8'hC3); add_byte(8'h89);
        add_byte(8'hC3); add_byte(8'hBC);
        add_byte(8'hC2); add_byte(8'hA9);
        // Bad lead bytes, an overlong NUL, three and four byte forms, broken sequences.
        add_byte(8'h80);
        add_byte(8'hFF);
        add_byte(8'hF8);
        add_byte(8'hC0); add_byte(8'h80);
        add_byte(8'hE2); add_byte(8'h82); add_byte(8'hAC);
        add_byte(8'hF7); add_byte(8'hBF); add_byte(8'hBF); add_byte(8'hBF);
        add_byte(8'hE0); add_byte(8'h00);
        add_byte(8'hC3); add_byte(8'h41);
        add_pause();
        add_random_sequences();
        quiet_tail = (TAIL_BYTES >= stim_bytes);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_sent != stim_bytes) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("utf8_glyph_decoder_tb OK");
        end else begin
            $display("utf8_glyph_decoder_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("utf8_glyph_decoder_tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
sv/ugd_pkg.sv
sv/ugd_front.sv
sv/ugd_queue.sv
sv/ugd_back.sv
sv/utf8_glyph_decoder.sv
sim/utf8_glyph_decoder_tb.sv
